// ===== sv/rrlts_pkg.sv =====
package rrlts_pkg;

   localparam int TICKET_W = 15;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WAKE_WT,
      ST_WAKE_APP,
      ST_RESCHED,
      ST_WALK,
      ST_PICK_RL,
      ST_PICK_WT,
      ST_PICK_GOT,
      ST_SHIFT,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef logic [2:0] status_type;

   localparam status_type STATUS_OK           = 3'd0;
   localparam status_type STATUS_READY_EMPTY  = 3'd1;
   localparam status_type STATUS_TABLE_FULL   = 3'd2;
   localparam status_type STATUS_SLEEP_EMPTY  = 3'd3;
   localparam status_type STATUS_TICKET_RANGE = 3'd4;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_CREATE  = 2'd0;
   localparam kind_type KIND_PREEMPT = 2'd1;
   localparam kind_type KIND_SLEEP   = 2'd2;
   localparam kind_type KIND_WAKE    = 2'd3;

endpackage

// ===== sv/rrlts_ram.sv =====
module rrlts_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_addr];
   end

endmodule

// ===== sv/round_robin_lottery_thread_scheduler.sv =====
// A create, a sleep-queue error or a table error finishes without a list walk; a preempt,
// sleep or wake with a nonempty ready list shifts the list from the picked position to the
// list end, and in lottery mode first walks the list up to the winner (an out-of-range ticket picks the last entry).
// One request is handled at a time; busy stays high until the result strobe.
// The ready list, sleep ring and weight table are single-port-write memories; reset is
// synchronous, needs no clearing pass, and results cannot be stalled by the receiver.
module round_robin_lottery_thread_scheduler #(
   parameter int THREAD_SLOTS = 128,
   parameter int WEIGHT_BITS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_kind,
   input  logic [WEIGHT_BITS-1:0]               req_weight,
   input  logic [rrlts_pkg::TICKET_W-1:0]       req_ticket,
   output logic                                 rsp_strobe,
   output logic [$clog2(THREAD_SLOTS)-1:0]      rsp_running_id,
   output logic                                 rsp_running_valid,
   output logic [$clog2(THREAD_SLOTS)-1:0]      rsp_created_id,
   output logic [2:0]                           rsp_status,
   output logic [$clog2(THREAD_SLOTS):0]        rsp_ready_count,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_write_data
);

   localparam int ID_W  = $clog2(THREAD_SLOTS);
   localparam int SUM_W = WEIGHT_BITS + ID_W;
   localparam int CMP_W = (SUM_W > rrlts_pkg::TICKET_W) ? SUM_W : rrlts_pkg::TICKET_W;
   localparam logic [ID_W:0]   SLOTS_C = (ID_W+1)'(THREAD_SLOTS);
   localparam logic [ID_W-1:0] LAST_C  = ID_W'(THREAD_SLOTS - 1);

   rrlts_pkg::state_type state_ff, state_in;
   logic                   mode_ff;
   rrlts_pkg::kind_type    kind_ff;
   logic [WEIGHT_BITS-1:0] weight_ff;
   logic [rrlts_pkg::TICKET_W-1:0] ticket_ff;
   rrlts_pkg::status_type  status_ff, status_in;
   logic [ID_W-1:0]        created_ff, created_in;
   logic [ID_W:0]          total_ff, total_in;
   logic [SUM_W-1:0]       wsum_ff, wsum_in;
   logic [ID_W-1:0]        shead_ff, shead_in;
   logic [ID_W:0]          stotal_ff, stotal_in;
   logic [ID_W:0]          made_ff, made_in;
   logic [ID_W-1:0]        cur_ff, cur_in;
   logic [WEIGHT_BITS-1:0] curw_ff, curw_in;
   logic                   curv_ff, curv_in;
   logic [ID_W-1:0]        pos_ff, pos_in;
   logic [ID_W-1:0]        picked_ff, picked_in;
   logic [WEIGHT_BITS-1:0] pickw_ff, pickw_in;
   logic [ID_W:0]          walk_rd_ff, walk_rd_in;
   logic                   v1_ff, v1_in, v2_ff, v2_in;
   logic [ID_W-1:0]        sidx_ff, sidx_in;
   logic [SUM_W-1:0]       run_ff, run_in;
   logic [ID_W:0]          sh_rd_ff, sh_rd_in;
   logic                   shv_ff, shv_in;
   logic [ID_W-1:0]        wa_ff, wa_in;

   logic                   rl_we, wt_we, sr_we;
   logic [ID_W-1:0]        rl_waddr, rl_wdata, rl_raddr, rl_q;
   logic [ID_W-1:0]        wt_waddr, wt_raddr;
   logic [WEIGHT_BITS-1:0] wt_wdata, wt_q;
   logic [ID_W-1:0]        sr_waddr, sr_wdata, sr_q;

   logic                   accept;
   logic [SUM_W-1:0]       run_sum;
   logic [ID_W:0]          total_dec;
   logic [SUM_W-1:0]       wsum_dec;
   logic [ID_W:0]          tail_sum;

   assign accept   = start && !busy;
   assign run_sum  = run_ff + SUM_W'(wt_q);
   assign total_dec = total_ff - 1'b1;
   assign wsum_dec = wsum_ff - SUM_W'(pickw_ff);
   assign tail_sum = {1'b0, shead_ff} + stotal_ff;

   rrlts_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(ID_W)) ready_ram (
      .clock(clock), .write_enable(rl_we), .write_addr(rl_waddr), .write_data(rl_wdata),
      .read_addr(rl_raddr), .read_data_ff(rl_q)
   );

   rrlts_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(WEIGHT_BITS)) weight_ram (
      .clock(clock), .write_enable(wt_we), .write_addr(wt_waddr), .write_data(wt_wdata),
      .read_addr(wt_raddr), .read_data_ff(wt_q)
   );

   rrlts_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(ID_W)) sleep_ram (
      .clock(clock), .write_enable(sr_we), .write_addr(sr_waddr), .write_data(sr_wdata),
      .read_addr(shead_ff), .read_data_ff(sr_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rrlts_pkg::ST_IDLE;
         mode_ff   <= 1'b0;
         total_ff  <= '0;
         wsum_ff   <= '0;
         shead_ff  <= '0;
         stotal_ff <= '0;
         made_ff   <= '0;
         cur_ff    <= '0;
         curv_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         total_ff  <= total_in;
         wsum_ff   <= wsum_in;
         shead_ff  <= shead_in;
         stotal_ff <= stotal_in;
         made_ff   <= made_in;
         cur_ff    <= cur_in;
         curv_ff   <= curv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= rrlts_pkg::kind_type'(req_kind);
         weight_ff <= req_weight;
         ticket_ff <= req_ticket;
      end
      status_ff  <= status_in;
      created_ff <= created_in;
      curw_ff    <= curw_in;
      pos_ff     <= pos_in;
      picked_ff  <= picked_in;
      pickw_ff   <= pickw_in;
      walk_rd_ff <= walk_rd_in;
      v1_ff      <= v1_in;
      v2_ff      <= v2_in;
      sidx_ff    <= sidx_in;
      run_ff     <= run_in;
      sh_rd_ff   <= sh_rd_in;
      shv_ff     <= shv_in;
      wa_ff      <= wa_in;
   end

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      created_in = created_ff;
      total_in   = total_ff;
      wsum_in    = wsum_ff;
      shead_in   = shead_ff;
      stotal_in  = stotal_ff;
      made_in    = made_ff;
      cur_in     = cur_ff;
      curw_in    = curw_ff;
      curv_in    = curv_ff;
      pos_in     = pos_ff;
      picked_in  = picked_ff;
      pickw_in   = pickw_ff;
      walk_rd_in = walk_rd_ff;
      v1_in      = 1'b0;
      v2_in      = 1'b0;
      sidx_in    = sidx_ff;
      run_in     = run_ff;
      sh_rd_in   = sh_rd_ff;
      shv_in     = 1'b0;
      wa_in      = wa_ff;
      rl_we      = 1'b0;
      rl_waddr   = total_ff[ID_W-1:0];
      rl_wdata   = made_ff[ID_W-1:0];
      rl_raddr   = pos_ff;
      wt_we      = 1'b0;
      wt_waddr   = made_ff[ID_W-1:0];
      wt_wdata   = '0;
      wt_raddr   = rl_q;
      sr_we      = 1'b0;
      sr_waddr   = (tail_sum >= SLOTS_C) ? ID_W'(tail_sum - SLOTS_C) : tail_sum[ID_W-1:0];
      sr_wdata   = cur_ff;
      busy       = (state_ff != rrlts_pkg::ST_IDLE);
      rsp_strobe = 1'b0;

      case (state_ff)
         rrlts_pkg::ST_IDLE: begin
            if (start) begin
               status_in  = rrlts_pkg::STATUS_OK;
               created_in = '0;
               state_in   = rrlts_pkg::ST_DISPATCH;
            end
         end
         rrlts_pkg::ST_DISPATCH: begin
            case (kind_ff)
               rrlts_pkg::KIND_CREATE: begin
                  state_in = rrlts_pkg::ST_DONE;
                  if (made_ff >= SLOTS_C) begin
                     status_in = rrlts_pkg::STATUS_TABLE_FULL;
                  end else begin
                     if (mode_ff) begin
                        wt_wdata = (weight_ff == '0) ? WEIGHT_BITS'(1) : weight_ff;
                     end
                     wt_we      = 1'b1;
                     created_in = made_ff[ID_W-1:0];
                     made_in    = made_ff + 1'b1;
                     if (total_ff < SLOTS_C) begin
                        rl_we    = 1'b1;
                        total_in = total_ff + 1'b1;
                        wsum_in  = wsum_ff + SUM_W'(wt_wdata);
                     end
                  end
               end
               rrlts_pkg::KIND_WAKE: begin
                  if (stotal_ff == '0) begin
                     status_in = rrlts_pkg::STATUS_SLEEP_EMPTY;
                     state_in  = rrlts_pkg::ST_DONE;
                  end else begin
                     state_in = rrlts_pkg::ST_WAKE_WT;
                  end
               end
               default: begin
                  state_in = rrlts_pkg::ST_RESCHED;
               end
            endcase
         end
         rrlts_pkg::ST_WAKE_WT: begin
            wt_raddr = sr_q;
            state_in = rrlts_pkg::ST_WAKE_APP;
         end
         rrlts_pkg::ST_WAKE_APP: begin
            shead_in  = (shead_ff == LAST_C) ? '0 : shead_ff + 1'b1;
            stotal_in = stotal_ff - 1'b1;
            if (total_ff < SLOTS_C) begin
               rl_we    = 1'b1;
               rl_wdata = sr_q;
               total_in = total_ff + 1'b1;
               wsum_in  = wsum_ff + SUM_W'(wt_q);
            end
            state_in = rrlts_pkg::ST_RESCHED;
         end
         rrlts_pkg::ST_RESCHED: begin
            walk_rd_in = '0;
            sidx_in    = '0;
            run_in     = '0;
            if (total_ff == '0) begin
               status_in = rrlts_pkg::STATUS_READY_EMPTY;
               state_in  = rrlts_pkg::ST_DONE;
            end else if (!mode_ff) begin
               pos_in   = '0;
               state_in = rrlts_pkg::ST_PICK_RL;
            end else if (CMP_W'(ticket_ff) >= CMP_W'(wsum_ff)) begin
               pos_in    = total_dec[ID_W-1:0];
               status_in = rrlts_pkg::STATUS_TICKET_RANGE;
               state_in  = rrlts_pkg::ST_PICK_RL;
            end else begin
               state_in = rrlts_pkg::ST_WALK;
            end
         end
         rrlts_pkg::ST_WALK: begin
            rl_raddr = (walk_rd_ff < total_ff) ? walk_rd_ff[ID_W-1:0] : '0;
            if (walk_rd_ff < total_ff) begin
               v1_in      = 1'b1;
               walk_rd_in = walk_rd_ff + 1'b1;
            end
            v2_in = v1_ff;
            if (v2_ff) begin
               if (CMP_W'(ticket_ff) < CMP_W'(run_sum)) begin
                  pos_in   = sidx_ff;
                  state_in = rrlts_pkg::ST_PICK_RL;
               end else begin
                  run_in  = run_sum;
                  sidx_in = sidx_ff + 1'b1;
               end
            end
         end
         rrlts_pkg::ST_PICK_RL: begin
            state_in = rrlts_pkg::ST_PICK_WT;
         end
         rrlts_pkg::ST_PICK_WT: begin
            picked_in = rl_q;
            state_in  = rrlts_pkg::ST_PICK_GOT;
         end
         rrlts_pkg::ST_PICK_GOT: begin
            pickw_in = wt_q;
            sh_rd_in = {1'b0, pos_ff} + 1'b1;
            state_in = rrlts_pkg::ST_SHIFT;
         end
         rrlts_pkg::ST_SHIFT: begin
            rl_raddr = (sh_rd_ff < total_ff) ? sh_rd_ff[ID_W-1:0] : '0;
            if (shv_ff) begin
               rl_we    = 1'b1;
               rl_waddr = wa_ff;
               rl_wdata = rl_q;
            end
            if (sh_rd_ff < total_ff) begin
               shv_in   = 1'b1;
               wa_in    = sh_rd_ff[ID_W-1:0] - 1'b1;
               sh_rd_in = sh_rd_ff + 1'b1;
            end else if (!shv_ff) begin
               state_in = rrlts_pkg::ST_FINISH;
            end
         end
         rrlts_pkg::ST_FINISH: begin
            total_in = total_dec;
            wsum_in  = wsum_dec;
            if (curv_ff) begin
               if (kind_ff == rrlts_pkg::KIND_SLEEP) begin
                  if (stotal_ff < SLOTS_C) begin
                     sr_we     = 1'b1;
                     stotal_in = stotal_ff + 1'b1;
                  end
               end else begin
                  rl_we    = 1'b1;
                  rl_waddr = total_dec[ID_W-1:0];
                  rl_wdata = cur_ff;
                  total_in = total_ff;
                  wsum_in  = wsum_dec + SUM_W'(curw_ff);
               end
            end
            cur_in   = picked_ff;
            curw_in  = pickw_ff;
            curv_in  = 1'b1;
            state_in = rrlts_pkg::ST_DONE;
         end
         rrlts_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = rrlts_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrlts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_running_id    = curv_ff ? cur_ff : '0;
   assign rsp_running_valid = curv_ff;
   assign rsp_created_id    = created_ff;
   assign rsp_status        = status_ff;
   assign rsp_ready_count   = total_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= SLOTS_C)
      else $error("ready count exceeds thread slots");

   a_pick_running: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == rrlts_pkg::STATUS_TICKET_RANGE) |-> rsp_running_valid)
      else $error("lottery pick left nothing running");

endmodule
